[src/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants and types for the line rasterizer: the item kind codes,
// the step vector codes and the bundle of step vectors for one line.
// ----------------------------------------------------------------------------
package blr_pkg;

    // Default coordinate width and depth of the command queue
    localparam int COORD_BITS_DEF = 12;
    localparam int CMD_DEPTH      = 4;

    // Item kind codes
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Y step codes, two's complement
    localparam logic [1:0] STEP_Y_ZERO = 2'b00;
    localparam logic [1:0] STEP_Y_UP   = 2'b01;
    localparam logic [1:0] STEP_Y_DOWN = 2'b11;

    // Step vectors A and B of one line
    typedef struct packed {
        logic       a_x;
        logic [1:0] a_y;
        logic       b_x;
        logic [1:0] b_y;
    } steps_t;

endpackage

[src/blr_front.sv]
// ----------------------------------------------------------------------------
// blr_front
// Input stage: accepts items, orders endpoints left to right, classifies the
// octant and builds step vectors, increments and the initial decision.
// ----------------------------------------------------------------------------
module blr_front #(
    parameter int CW = blr_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 push,
    output logic                 full,
    input  logic                 kind,
    input  logic [CW-1:0]        start_x,
    input  logic [CW-1:0]        start_y,
    input  logic [CW-1:0]        end_x,
    input  logic [CW-1:0]        end_y,
    // command channel toward the queue
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output logic                 cmd_kind,
    output blr_pkg::steps_t      cmd_steps,
    output logic [CW-1:0]        cmd_x0,
    output logic [CW-1:0]        cmd_y0,
    output logic [CW-1:0]        cmd_x1,
    output logic [CW-1:0]        cmd_y1,
    output logic signed [CW+2:0] cmd_inc_a,
    output logic signed [CW+2:0] cmd_inc_b,
    output logic signed [CW+2:0] cmd_dec
);

    localparam int DW = CW + 3;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_kind_reg;
    logic [CW-1:0]        s1_x0_reg;
    logic [CW-1:0]        s1_y0_reg;
    logic [CW-1:0]        s1_x1_reg;
    logic [CW-1:0]        s1_y1_reg;
    logic [CW-1:0]        s1_dx_reg;
    logic signed [CW:0]   s1_dy_reg;
    logic [CW-1:0]        s1_ady_reg;
    logic                 s1_rising_reg;

    logic                 in_ready;
    logic                 in_take;
    logic                 swap;
    logic [CW-1:0]        lx0;
    logic [CW-1:0]        ly0;
    logic [CW-1:0]        lx1;
    logic [CW-1:0]        ly1;
    logic                 rising;

    logic                 shallow;
    logic signed [DW-1:0] dx_e;
    logic signed [DW-1:0] dy_e;
    logic signed [DW-1:0] dx2;
    logic signed [DW-1:0] dy2;

    // Stage one is free or drains this cycle
    assign in_ready = !s1_valid_reg || cmd_ready;
    assign full     = !in_ready;
    assign in_take  = push && in_ready;

    // Order endpoints so that x never decreases
    assign swap   = start_x > end_x;
    assign lx0    = swap ? end_x   : start_x;
    assign ly0    = swap ? end_y   : start_y;
    assign lx1    = swap ? start_x : end_x;
    assign ly1    = swap ? start_y : end_y;
    assign rising = ly0 <= ly1;

    // Advance stage valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture ordered endpoints and deltas
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg   <= kind;
            s1_x0_reg     <= lx0;
            s1_y0_reg     <= ly0;
            s1_x1_reg     <= lx1;
            s1_y1_reg     <= ly1;
            s1_dx_reg     <= lx1 - lx0;
            s1_dy_reg     <= $signed({1'b0, ly1}) - $signed({1'b0, ly0});
            s1_ady_reg    <= rising ? (ly1 - ly0) : (ly0 - ly1);
            s1_rising_reg <= rising;
        end
    end

    // Classify octant and build increments
    assign shallow = s1_dx_reg >= s1_ady_reg;
    assign dx_e    = $signed({3'b000, s1_dx_reg});
    assign dy_e    = $signed({{2{s1_dy_reg[CW]}}, s1_dy_reg});
    assign dx2     = dx_e <<< 1;
    assign dy2     = dy_e <<< 1;

    always_comb
    begin
        cmd_steps = '0;
        cmd_inc_a = '0;
        cmd_inc_b = '0;
        cmd_dec   = '0;
        if (s1_rising_reg && shallow)
        begin
            cmd_steps = '{a_x: 1'b1, a_y: blr_pkg::STEP_Y_ZERO,
                          b_x: 1'b1, b_y: blr_pkg::STEP_Y_UP};
            cmd_inc_a = dy2;
            cmd_inc_b = dy2 - dx2;
            cmd_dec   = dy2 - dx_e;
        end
        else if (s1_rising_reg)
        begin
            cmd_steps = '{a_x: 1'b1, a_y: blr_pkg::STEP_Y_UP,
                          b_x: 1'b0, b_y: blr_pkg::STEP_Y_UP};
            cmd_inc_a = dy2 - dx2;
            cmd_inc_b = -dx2;
            cmd_dec   = dy_e - dx2;
        end
        else if (shallow)
        begin
            cmd_steps = '{a_x: 1'b1, a_y: blr_pkg::STEP_Y_DOWN,
                          b_x: 1'b1, b_y: blr_pkg::STEP_Y_ZERO};
            cmd_inc_a = dx2 + dy2;
            cmd_inc_b = dy2;
            cmd_dec   = dy2 + dx_e;
        end
        else
        begin
            cmd_steps = '{a_x: 1'b0, a_y: blr_pkg::STEP_Y_DOWN,
                          b_x: 1'b1, b_y: blr_pkg::STEP_Y_DOWN};
            cmd_inc_a = dx2;
            cmd_inc_b = dx2 + dy2;
            cmd_dec   = dy_e + dx2;
        end
    end

    assign cmd_valid = s1_valid_reg;
    assign cmd_kind  = s1_kind_reg;
    assign cmd_x0    = s1_x0_reg;
    assign cmd_y0    = s1_y0_reg;
    assign cmd_x1    = s1_x1_reg;
    assign cmd_y1    = s1_y1_reg;

endmodule

[src/blr_queue.sv]
// ----------------------------------------------------------------------------
// blr_queue
// Small first-in first-out command queue between the front and back parts.
// ----------------------------------------------------------------------------
module blr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = blr_pkg::CMD_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = count_reg != FULL_CNT;
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/blr_back.sv]
// ----------------------------------------------------------------------------
// blr_back
// Execution part: holds the active line, emits one pixel per start and per
// active-line advance; an output register keeps the result until it is popped.
// ----------------------------------------------------------------------------
module blr_back #(
    parameter int CW = blr_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel from the queue
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic                 cmd_kind,
    input  blr_pkg::steps_t      cmd_steps,
    input  logic [CW-1:0]        cmd_x0,
    input  logic [CW-1:0]        cmd_y0,
    input  logic [CW-1:0]        cmd_x1,
    input  logic [CW-1:0]        cmd_y1,
    input  logic signed [CW+2:0] cmd_inc_a,
    input  logic signed [CW+2:0] cmd_inc_b,
    input  logic signed [CW+2:0] cmd_dec,
    // result channel
    output logic                 empty,
    input  logic                 pop,
    output logic [CW-1:0]        pixel_x,
    output logic [CW-1:0]        pixel_y,
    output logic                 last
);

    localparam int DW = CW + 3;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CW-1:0]        cur_x_reg;
    logic [CW-1:0]        cur_x_next;
    logic [CW-1:0]        cur_y_reg;
    logic [CW-1:0]        cur_y_next;
    logic [CW-1:0]        goal_x_reg;
    logic [CW-1:0]        goal_x_next;
    logic [CW-1:0]        goal_y_reg;
    logic [CW-1:0]        goal_y_next;
    logic signed [DW-1:0] dec_reg;
    logic signed [DW-1:0] dec_next;
    logic signed [DW-1:0] inc_a_reg;
    logic signed [DW-1:0] inc_a_next;
    logic signed [DW-1:0] inc_b_reg;
    logic signed [DW-1:0] inc_b_next;
    blr_pkg::steps_t      steps_reg;
    blr_pkg::steps_t      steps_next;
    logic [CW-1:0]        pixel_x_reg;
    logic [CW-1:0]        pixel_y_reg;
    logic                 last_reg;

    logic                 take;
    logic                 is_start;
    logic                 emit;
    logic                 neg;
    logic                 step_x;
    logic [1:0]           step_y;
    logic                 fin;

    assign take     = cmd_valid && (!out_valid_reg || pop);
    assign cmd_ready = take;
    assign is_start = cmd_kind == blr_pkg::KIND_START;
    assign emit     = take && (is_start || busy_reg);

    // Pick step A on a negative decision, else step B
    assign neg    = dec_reg[DW-1];
    assign step_x = neg ? steps_reg.a_x : steps_reg.b_x;
    assign step_y = neg ? steps_reg.a_y : steps_reg.b_y;

    // Load a new line or advance the active one
    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        dec_next    = dec_reg;
        inc_a_next  = inc_a_reg;
        inc_b_next  = inc_b_reg;
        steps_next  = steps_reg;
        if (is_start)
        begin
            cur_x_next  = cmd_x0;
            cur_y_next  = cmd_y0;
            goal_x_next = cmd_x1;
            goal_y_next = cmd_y1;
            dec_next    = cmd_dec;
            inc_a_next  = cmd_inc_a;
            inc_b_next  = cmd_inc_b;
            steps_next  = cmd_steps;
        end
        else
        begin
            cur_x_next = cur_x_reg + {{(CW-1){1'b0}}, step_x};
            cur_y_next = cur_y_reg + {{(CW-2){step_y[1]}}, step_y};
            dec_next   = dec_reg + (neg ? inc_a_reg : inc_b_reg);
        end
    end

    assign fin = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);

    // Control: line activity and output register occupancy
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            busy_next      = !fin;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold line state and the emitted pixel
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            goal_x_reg  <= goal_x_next;
            goal_y_reg  <= goal_y_next;
            dec_reg     <= dec_next;
            inc_a_reg   <= inc_a_next;
            inc_b_reg   <= inc_b_next;
            steps_reg   <= steps_next;
            pixel_x_reg <= cur_x_next;
            pixel_y_reg <= cur_y_next;
            last_reg    <= fin;
        end
    end

    assign empty   = !out_valid_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign last    = last_reg;

endmodule

[src/bresenham_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Midpoint line rasterizer: one pixel per start and per active-line advance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push/full. A beat with kind = start carries two endpoints
//   and yields the line's first pixel; a beat with kind = advance yields the
//   next pixel, or nothing when no line is active.
//   Result channel: empty/pop. pixel_x, pixel_y and last are valid while
//   empty is low; last marks the line's end point.
//   Path: a beat passes the front register, the command queue and the
//   output register before its result shows on the outputs.
//   Throughput: one item per cycle while results are popped. The back part
//   updates the decision and coordinates together, so pixels go back to back.
//   Stall: while a result waits, the back part holds; the command queue of
//   QUEUE_DEPTH entries and the front register keep taking beats until full.
//   Reset: rst_n clears all valid state; no line is active, the queue and
//   the output register are empty, and full is low.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = blr_pkg::CMD_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 3;
    localparam int SW  = $bits(blr_pkg::steps_t);
    localparam int QW  = 1 + SW + 4 * CW + 3 * DW;

    logic                 f_valid;
    logic                 f_ready;
    logic                 f_kind;
    blr_pkg::steps_t      f_steps;
    logic [CW-1:0]        f_x0;
    logic [CW-1:0]        f_y0;
    logic [CW-1:0]        f_x1;
    logic [CW-1:0]        f_y1;
    logic signed [DW-1:0] f_inc_a;
    logic signed [DW-1:0] f_inc_b;
    logic signed [DW-1:0] f_dec;

    logic [QW-1:0]        q_wr_data;
    logic [QW-1:0]        q_rd_data;
    logic                 b_valid;
    logic                 b_ready;
    logic                 b_kind;
    blr_pkg::steps_t      b_steps;
    logic [CW-1:0]        b_x0;
    logic [CW-1:0]        b_y0;
    logic [CW-1:0]        b_x1;
    logic [CW-1:0]        b_y1;
    logic signed [DW-1:0] b_inc_a;
    logic signed [DW-1:0] b_inc_b;
    logic signed [DW-1:0] b_dec;

    // Front: accept and classify
    blr_front #(
        .CW (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_kind  (f_kind),
        .cmd_steps (f_steps),
        .cmd_x0    (f_x0),
        .cmd_y0    (f_y0),
        .cmd_x1    (f_x1),
        .cmd_y1    (f_y1),
        .cmd_inc_a (f_inc_a),
        .cmd_inc_b (f_inc_b),
        .cmd_dec   (f_dec)
    );

    // Pack and unpack the command beat
    assign q_wr_data = {f_kind, f_steps, f_x0, f_y0, f_x1, f_y1,
                        f_inc_a, f_inc_b, f_dec};
    assign {b_kind, b_steps, b_x0, b_y0, b_x1, b_y1,
            b_inc_a, b_inc_b, b_dec} = q_rd_data;

    // Command queue between front and back
    blr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (q_rd_data)
    );

    // Back: step the line and register the result
    blr_back #(
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_kind  (b_kind),
        .cmd_steps (b_steps),
        .cmd_x0    (b_x0),
        .cmd_y0    (b_y0),
        .cmd_x1    (b_x1),
        .cmd_y1    (b_y1),
        .cmd_inc_a (b_inc_a),
        .cmd_inc_b (b_inc_b),
        .cmd_dec   (b_dec),
        .empty     (empty),
        .pop       (pop),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

endmodule

[src/blr_checker.sv]
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module blr_checker #(
    parameter int CW = blr_pkg::COORD_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input logic [CW-1:0] pixel_x,
    input logic [CW-1:0] pixel_y,
    input logic          last
);

    localparam int PW = 16;

    logic [PW-1:0] pend_reg;
    logic [PW-1:0] pend_next;
    logic          sat_reg;
    logic          sat_next;
    logic          in_beat;
    logic          out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    // Track beats taken but not yet matched by a result; stick once saturated
    always_comb
    begin
        pend_next = pend_reg;
        sat_next  = sat_reg;
        if (!sat_reg)
        begin
            if (in_beat && !out_beat)
            begin
                if (pend_reg == {PW{1'b1}})
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg + 1'b1;
                end
            end
            else if (out_beat && !in_beat && pend_reg != '0)
            begin
                pend_next = pend_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            sat_reg  <= sat_next;
        end
    end

    // Reset leaves both sides idle once it has been seen at a clock edge
    a_reset_idle: assert property (@(posedge clk)
        (!rst_n && $past(!rst_n)) |-> (empty && !full))
        else $error("channels not idle during reset");

    // A waiting result stays until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before pop");

    // A stalled result keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(pixel_x) && $stable(pixel_y) && $stable(last)))
        else $error("stalled result changed");

    // No result without an earlier input beat
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (sat_reg || pend_reg != '0))
        else $error("result delivered with no pending input beat");

endmodule

bind bresenham_line_rasterizer_core blr_checker #(
    .CW (COORD_BITS)
) u_blr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .last    (last)
);
